>>> rtl/mcoc_pkg.sv
// ----------------------------------------------------------------------------
// mcoc_pkg - shared definitions for the matrix chain order cost block
// Field widths, default sizes, sequencer states and control groups.
// ----------------------------------------------------------------------------
`default_nettype none

package mcoc_pkg;

   localparam int MAX_MATRICES_DEF = 32;
   localparam int COST_BITS_DEF    = 48;

   localparam int DIM_W        = 12;
   localparam int PROD_W       = 3 * DIM_W;
   localparam int MIN_COST_W   = 48;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 48;
   localparam int SHORT_CHAIN  = 3;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CELL,
      ST_PROD,
      ST_RUN,
      ST_DRAIN,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic left_zero;
      logic right_zero;
   } mac_ctrl_type;

   typedef struct packed {
      logic load;
      logic zero;
      logic too_many;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/mcoc_mac.sv
// ----------------------------------------------------------------------------
// mcoc_mac - shared multiply-add-compare unit
// Forms d(i)*d(k)*d(j) + cost(i,k) + cost(k,j) with saturation and keeps the
// running minimum of the cell being filled. Two stages after the memory read.
// ----------------------------------------------------------------------------
`default_nettype none

module mcoc_mac #(
   parameter int COST_BITS = mcoc_pkg::COST_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mcoc_pkg::mac_ctrl_type       ctrl,
   input  wire logic [mcoc_pkg::DIM_W-1:0]   dim_a,
   input  wire logic [mcoc_pkg::DIM_W-1:0]   dim_b,
   input  wire logic [COST_BITS-1:0]         cost_a,
   input  wire logic [COST_BITS-1:0]         cost_b,
   output logic                              busy,
   output logic [COST_BITS-1:0]              best
);

   localparam int PW    = mcoc_pkg::PROD_W;
   localparam int DD_W  = 2 * mcoc_pkg::DIM_W;
   localparam int SUM_W = ((COST_BITS > PW) ? COST_BITS : PW) + 2;
   localparam logic [COST_BITS-1:0] LIM = '1;

   logic                 v1_ff, v2_ff, have_ff;
   logic                 lz_ff, rz_ff;
   logic [DD_W-1:0]      didj_ff;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [COST_BITS:0]   ab_ff, ab_in;
   logic [COST_BITS-1:0] best_ff;
   logic [SUM_W-1:0]     total;
   logic [COST_BITS-1:0] sat;
   logic                 take;

   always_comb begin
      prod_in = PW'(didj_ff) * PW'(dim_a);
      ab_in   = (lz_ff ? '0 : {1'b0, cost_a}) + (rz_ff ? '0 : {1'b0, cost_b});
      total   = SUM_W'(ab_ff) + SUM_W'(prod_ff);
      sat     = (total > SUM_W'(LIM)) ? LIM : total[COST_BITS-1:0];
      take    = v2_ff && (!have_ff || (sat < best_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.issue;
         v2_ff <= v1_ff;
         if (ctrl.start) begin
            have_ff <= 1'b0;
         end else if (take) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      lz_ff <= ctrl.left_zero;
      rz_ff <= ctrl.right_zero;
      if (ctrl.start) begin
         didj_ff <= DD_W'(dim_a) * DD_W'(dim_b);
      end
      if (v1_ff) begin
         prod_ff <= prod_in;
         ab_ff   <= ab_in;
      end
      if (take) begin
         best_ff <= sat;
      end
   end

   assign busy = v1_ff | v2_ff;
   assign best = best_ff;

endmodule

`default_nettype wire

>>> rtl/mcoc_seq.sv
// ----------------------------------------------------------------------------
// mcoc_seq - load and table-fill sequencer
// Collects dimensions, then walks the cost table diagonal by diagonal and
// issues one split point per cycle to the shared unit while filling a cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mcoc_seq #(
   parameter  int MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF,
   localparam int DEPTH        = MAX_MATRICES + 1,
   localparam int IDX_W        = $clog2(DEPTH),
   localparam int CNT_W        = $clog2(DEPTH + 1),
   localparam int CA_W         = $clog2(DEPTH * DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tlast,
   output logic                        req_tready,
   input  wire logic                   mac_busy,
   input  wire logic                   out_free,
   output logic                        dim_we,
   output logic [IDX_W-1:0]            dim_waddr,
   output logic [IDX_W-1:0]            dim_raddr_a,
   output logic [IDX_W-1:0]            dim_raddr_b,
   output logic [CA_W-1:0]             cost_raddr_a,
   output logic [CA_W-1:0]             cost_raddr_b,
   output logic                        cost_we,
   output logic [CA_W-1:0]             cost_waddr,
   output mcoc_pkg::mac_ctrl_type      mac_ctrl,
   output mcoc_pkg::result_type        result
);

   mcoc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_new;
   logic             ovf_ff, ovf_in;
   logic             short_ff, short_in;
   logic [IDX_W-1:0] n_ff, n_in, len_ff, len_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CA_W-1:0]  rowi_ff, rowi_in, rowk_ff, rowk_in;
   logic             accept, has_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcoc_pkg::ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      short_ff <= short_in;
      n_ff     <= n_in;
      len_ff   <= len_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      rowi_ff  <= rowi_in;
      rowk_ff  <= rowk_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      short_in = short_ff;
      n_in     = n_ff;
      len_in   = len_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      rowi_in  = rowi_ff;
      rowk_in  = rowk_ff;

      req_tready   = 1'b0;
      accept       = 1'b0;
      has_room     = cnt_ff < CNT_W'(DEPTH);
      cnt_new      = cnt_ff + CNT_W'(has_room);
      dim_we       = 1'b0;
      dim_waddr    = cnt_ff[IDX_W-1:0];
      dim_raddr_a  = i_ff;
      dim_raddr_b  = j_ff;
      cost_raddr_a = rowi_ff + CA_W'(k_ff);
      cost_raddr_b = rowk_ff + CA_W'(j_ff);
      cost_we      = 1'b0;
      cost_waddr   = rowi_ff + CA_W'(j_ff);
      mac_ctrl     = '0;
      result       = '0;

      unique case (state_ff)
         mcoc_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               dim_we = has_room;
               cnt_in = cnt_new;
               ovf_in = ovf_ff | !has_room;
               if (req_tlast) begin
                  n_in    = IDX_W'(cnt_new - CNT_W'(1));
                  len_in  = IDX_W'(2);
                  i_in    = '0;
                  j_in    = IDX_W'(2);
                  rowi_in = '0;
                  if (cnt_new < CNT_W'(mcoc_pkg::SHORT_CHAIN)) begin
                     short_in = 1'b1;
                     state_in = mcoc_pkg::ST_FIN;
                  end else begin
                     short_in = 1'b0;
                     state_in = mcoc_pkg::ST_CELL;
                  end
               end
            end
         end
         mcoc_pkg::ST_CELL: begin
            // fetch d(i) and d(j) for the new cell
            state_in = mcoc_pkg::ST_PROD;
         end
         mcoc_pkg::ST_PROD: begin
            mac_ctrl.start = 1'b1;
            k_in     = i_ff + IDX_W'(1);
            rowk_in  = rowi_ff + CA_W'(DEPTH);
            state_in = mcoc_pkg::ST_RUN;
         end
         mcoc_pkg::ST_RUN: begin
            dim_raddr_a         = k_ff;
            mac_ctrl.issue      = 1'b1;
            // single-matrix intervals cost nothing and are never stored
            mac_ctrl.left_zero  = (k_ff == i_ff + IDX_W'(1));
            mac_ctrl.right_zero = (k_ff == j_ff - IDX_W'(1));
            if (mac_ctrl.right_zero) begin
               state_in = mcoc_pkg::ST_DRAIN;
            end else begin
               k_in    = k_ff + IDX_W'(1);
               rowk_in = rowk_ff + CA_W'(DEPTH);
            end
         end
         mcoc_pkg::ST_DRAIN: begin
            if (!mac_busy) begin
               cost_we = 1'b1;
               if (j_ff == n_ff) begin
                  if (len_ff == n_ff) begin
                     state_in = mcoc_pkg::ST_FIN;
                  end else begin
                     len_in   = len_ff + IDX_W'(1);
                     i_in     = '0;
                     j_in     = len_ff + IDX_W'(1);
                     rowi_in  = '0;
                     state_in = mcoc_pkg::ST_CELL;
                  end
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = j_ff + IDX_W'(1);
                  rowi_in  = rowi_ff + CA_W'(DEPTH);
                  state_in = mcoc_pkg::ST_CELL;
               end
            end
         end
         mcoc_pkg::ST_FIN: begin
            // hold until the output register can take the result
            if (out_free) begin
               result.load     = 1'b1;
               result.zero     = short_ff;
               result.too_many = ovf_ff;
               cnt_in          = '0;
               ovf_in          = 1'b0;
               state_in        = mcoc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mcoc_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/matrix_chain_order_cost.sv
// ----------------------------------------------------------------------------
// matrix_chain_order_cost - least scalar-multiplication count of a chain
// Loads d0..dn one per transfer, fills the interval cost table with one
// shared multiply-add-compare unit and returns the minimum cost.
// ----------------------------------------------------------------------------
// Dimensions are taken while loading; after the last one the table is filled
// cell by cell, each split point passing through the single shared unit.
// Throughput: one chain at a time; input is not ready during the table fill.
// Reset clears the sequencer, dimension count, overflow flag and output valid;
// no memory clearing pass is needed.
`default_nettype none

module matrix_chain_order_cost #(
   parameter int MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF,
   parameter int COST_BITS    = mcoc_pkg::COST_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [mcoc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [11:0] dim
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [mcoc_pkg::RSP_TDATA_W-1:0]        rsp_tdata,  // [47:0] min_cost
   output logic                                    rsp_tuser   // [0] too_many
);

   localparam int DEPTH = MAX_MATRICES + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CA_W  = $clog2(DEPTH * DEPTH);
   localparam int DW    = mcoc_pkg::DIM_W;
   localparam int OW    = mcoc_pkg::MIN_COST_W;
   localparam int EXT_W = (COST_BITS > OW) ? COST_BITS : OW;

   logic [DW-1:0]        dim_mem [DEPTH];
   logic [COST_BITS-1:0] cost_mem [DEPTH * DEPTH];

   logic                 dim_we, cost_we, mac_busy, out_free;
   logic [IDX_W-1:0]     dim_waddr, dim_raddr_a, dim_raddr_b;
   logic [CA_W-1:0]      cost_raddr_a, cost_raddr_b, cost_waddr;
   logic [DW-1:0]        dim_rd_a_ff, dim_rd_b_ff;
   logic [COST_BITS-1:0] cost_rd_a_ff, cost_rd_b_ff, best;
   logic [EXT_W-1:0]     best_ext;
   mcoc_pkg::mac_ctrl_type mac_ctrl;
   mcoc_pkg::result_type   result;

   logic                 rsp_valid_ff;
   logic [OW-1:0]        rsp_cost_ff;
   logic                 rsp_flag_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   mcoc_seq #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tlast    (req_tlast),
      .req_tready   (req_tready),
      .mac_busy     (mac_busy),
      .out_free     (out_free),
      .dim_we       (dim_we),
      .dim_waddr    (dim_waddr),
      .dim_raddr_a  (dim_raddr_a),
      .dim_raddr_b  (dim_raddr_b),
      .cost_raddr_a (cost_raddr_a),
      .cost_raddr_b (cost_raddr_b),
      .cost_we      (cost_we),
      .cost_waddr   (cost_waddr),
      .mac_ctrl     (mac_ctrl),
      .result       (result)
   );

   mcoc_mac #(
      .COST_BITS (COST_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .dim_a  (dim_rd_a_ff),
      .dim_b  (dim_rd_b_ff),
      .cost_a (cost_rd_a_ff),
      .cost_b (cost_rd_b_ff),
      .busy   (mac_busy),
      .best   (best)
   );

   // dimension store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (dim_we) begin
         dim_mem[dim_waddr] <= req_tdata[DW-1:0];
      end
      dim_rd_a_ff <= dim_mem[dim_raddr_a];
      dim_rd_b_ff <= dim_mem[dim_raddr_b];
   end

   // cost table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_waddr] <= best;
      end
      cost_rd_a_ff <= cost_mem[cost_raddr_a];
      cost_rd_b_ff <= cost_mem[cost_raddr_b];
   end

   assign best_ext = EXT_W'(best);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_cost_ff <= result.zero ? '0 : best_ext[OW-1:0];
         rsp_flag_ff <= result.too_many;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cost_ff;
   assign rsp_tuser  = rsp_flag_ff;

endmodule

`default_nettype wire
